// File: src/mfba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfba_pkg
// Shared constants and types of the breadth-first max-flow block.
// ----------------------------------------------------------------------------
package mfba_pkg;

  localparam int MAX_NODES = 64;
  localparam int CAP_WIDTH = 16;

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int RES_W     = CAP_WIDTH + 1;
  localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
  localparam int MAT_AW    = 2 * NODE_W;
  localparam int QUEUE_W   = NODE_W + RES_W;
  localparam int TOTAL_W   = 23;
  localparam int FLOW_W    = 22;

  localparam int MODE_W    = 2;
  localparam int FIELD_NW  = 6;
  localparam int ECAP_W    = 16;
  localparam int NCOUNT_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 7;

  localparam logic [RES_W-1:0]   RES_MAX   = {RES_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [FLOW_W-1:0]  OUT_MAX   = {FLOW_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 2'd0,
    MODE_COMPUTE = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_COUNT  = 2'd0,
    REG_SOURCE_NODE = 2'd1,
    REG_SINK_NODE   = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

endpackage
`default_nettype wire

// File: src/mfba_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfba_in_if
// Input item channel: valid, ready and the matrix or command payload.
// ----------------------------------------------------------------------------
interface mfba_in_if;
  import mfba_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [FIELD_NW-1:0] from_node;
  logic [FIELD_NW-1:0] to_node;
  logic [ECAP_W-1:0]   edge_capacity;

  modport source (output valid, mode, from_node, to_node, edge_capacity, input ready);
  modport sink   (input valid, mode, from_node, to_node, edge_capacity, output ready);
endinterface
`default_nettype wire

// File: src/mfba_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfba_out_if
// Result item channel: valid, ready and the computed flow.
// ----------------------------------------------------------------------------
interface mfba_out_if;
  import mfba_pkg::*;

  logic              valid;
  logic              ready;
  logic [FLOW_W-1:0] max_flow;

  modport source (output valid, max_flow, input ready);
  modport sink   (input valid, max_flow, output ready);
endinterface
`default_nettype wire

// File: src/mfba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfba_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/max_flow_bfs_augment.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_flow_bfs_augment
// Edmonds-Karp maximum flow over a capacity matrix held in on-chip RAM.
// ----------------------------------------------------------------------------
// Write items load capacity entries one item per cycle while idle, and a
// clear item zeroes the whole matrix. A compute item runs breadth-first
// searches from source_node to sink_node, each scanning a matrix row in
// index order, then walks the found path back through the parent table,
// lowering forward residuals and raising reverse ones by the bottleneck.
// When no path remains the summed flow is returned as one result item.
// Compute leaves residuals in the matrix, so reload it before a new compute.
// Sequencing: a clear item, and the pass that follows reset, sweeps the
// matrix one entry per cycle, during which no item is taken (configuration
// writes still are). A compute item is bounded by the single matrix read
// port: every scanned entry is read and then checked, and every path hop
// reads the parent and the forward entry, then writes the forward and the
// reverse residual in turn. Only one item is in progress at a time; the
// result register lets write items continue while a finished result waits
// to be taken.
// ----------------------------------------------------------------------------
module max_flow_bfs_augment (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mfba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mfba_pkg::CFG_DW-1:0]    cfg_wdata,
  mfba_in_if.sink                            in_ch,
  mfba_out_if.source                         out_ch
);
  import mfba_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [11:0] {
    S_CLEAR    = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_INIT     = 12'b0000_0000_0100,
    S_POP      = 12'b0000_0000_1000,
    S_POPW     = 12'b0000_0001_0000,
    S_SCAN_RD  = 12'b0000_0010_0000,
    S_SCAN_CHK = 12'b0000_0100_0000,
    S_AUG_P    = 12'b0000_1000_0000,
    S_AUG_PW   = 12'b0001_0000_0000,
    S_AUG_FW   = 12'b0010_0000_0000,
    S_AUG_BW   = 12'b0100_0000_0000,
    S_FINISH   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [NCOUNT_W-1:0] node_count_r;
  logic [NODE_W-1:0]   source_r, sink_r;

  // Search and augmentation registers.
  logic [MAT_AW:0]      clr_addr_r, clr_addr_nxt;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [CNT_W-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]     nx_r, nx_nxt, hops_r, hops_nxt;
  logic [NODE_W-1:0]    cur_r, cur_nxt, prev_r, prev_nxt;
  logic [RES_W-1:0]     lim_r, lim_nxt, f_r, f_nxt;
  logic [TOTAL_W-1:0]   flow_r, flow_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [FLOW_W-1:0]    out_flow_r, out_flow_nxt;

  // RAM ports.
  logic              mat_we, par_we, q_we;
  logic [MAT_AW-1:0] mat_waddr, mat_raddr;
  logic [RES_W-1:0]  mat_wdata, mat_rdata;
  logic [NODE_W-1:0] par_waddr, par_raddr, par_wdata, par_rdata;
  logic [NODE_W-1:0] q_waddr, q_raddr;
  logic [QUEUE_W-1:0] q_wdata, q_rdata;

  // Helpers.
  logic [CNT_W-1:0]   n_eff;
  logic               accept;
  logic [RES_W-1:0]   bneck;
  logic [RES_W:0]     bw_sum;
  logic [TOTAL_W:0]   flow_sum;
  logic [NODE_W-1:0]  nx_idx;

  mfba_ram #(.WIDTH(RES_W), .DEPTH(MAT_DEPTH)) u_matrix (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rdata)
  );

  mfba_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  mfba_ram #(.WIDTH(QUEUE_W), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // A node count above the matrix size behaves as the full matrix.
  assign n_eff = (node_count_r > NCOUNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(node_count_r);
  assign nx_idx = nx_r[NODE_W-1:0];
  assign bneck  = (lim_r < mat_rdata) ? lim_r : mat_rdata;
  assign bw_sum = {1'b0, mat_rdata} + {1'b0, f_r};
  // The flow is credited in the cycle the sink is reached, with that path's bottleneck.
  assign flow_sum = {1'b0, flow_r} + (TOTAL_W+1)'(bneck);

  assign in_ch.ready     = (state_r == S_IDLE);
  assign accept          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.max_flow = out_flow_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    visited_nxt   = visited_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    nx_nxt        = nx_r;
    hops_nxt      = hops_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    lim_nxt       = lim_r;
    f_nxt         = f_r;
    flow_nxt      = flow_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_flow_nxt  = out_flow_r;

    mat_we    = 1'b0;
    mat_waddr = {cur_r, nx_idx};
    mat_wdata = '0;
    mat_raddr = {cur_r, nx_idx};
    par_we    = 1'b0;
    par_waddr = nx_idx;
    par_wdata = cur_r;
    par_raddr = cur_r;
    q_we      = 1'b0;
    q_waddr   = tail_r[NODE_W-1:0];
    q_wdata   = {nx_idx, bneck};
    q_raddr   = head_r[NODE_W-1:0];

    case (state_r)
      S_CLEAR: begin
        mat_we    = 1'b1;
        mat_waddr = clr_addr_r[MAT_AW-1:0];
        mat_wdata = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == (MAT_AW+1)'(MAT_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (mode_t'(in_ch.mode))
            MODE_WRITE: begin
              mat_we    = 1'b1;
              mat_waddr = {in_ch.from_node[NODE_W-1:0], in_ch.to_node[NODE_W-1:0]};
              mat_wdata = RES_W'(in_ch.edge_capacity[CAP_WIDTH-1:0]);
            end
            MODE_COMPUTE: begin
              flow_nxt = '0;
              if (CNT_W'(source_r) >= n_eff || CNT_W'(sink_r) >= n_eff) begin
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_INIT;
              end
            end
            MODE_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        // Start a new search with only the source in the queue.
        visited_nxt = '0;
        visited_nxt[source_r] = 1'b1;
        q_we     = 1'b1;
        q_waddr  = '0;
        q_wdata  = {source_r, RES_MAX};
        head_nxt = '0;
        tail_nxt = CNT_W'(1);
        state_nxt = S_POP;
      end
      S_POP: begin
        if (head_r < tail_r) begin
          head_nxt  = head_r + 1'b1;
          state_nxt = S_POPW;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_POPW: begin
        cur_nxt   = q_rdata[QUEUE_W-1:RES_W];
        lim_nxt   = q_rdata[RES_W-1:0];
        nx_nxt    = '0;
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (nx_r == n_eff) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        nx_nxt    = nx_r + 1'b1;
        state_nxt = S_SCAN_RD;
        if (!visited_r[nx_idx] && mat_rdata != '0) begin
          visited_nxt[nx_idx] = 1'b1;
          par_we = 1'b1;
          if (nx_idx == sink_r) begin
            // Path found: credit the flow and walk back from the sink.
            f_nxt     = bneck;
            flow_nxt  = flow_sum[TOTAL_W] ? TOTAL_MAX : flow_sum[TOTAL_W-1:0];
            cur_nxt   = sink_r;
            hops_nxt  = '0;
            state_nxt = S_AUG_P;
          end else if (tail_r < CNT_W'(MAX_NODES)) begin
            q_we     = 1'b1;
            tail_nxt = tail_r + 1'b1;
          end
        end
      end
      S_AUG_P: begin
        if (cur_r == source_r || hops_r == CNT_W'(MAX_NODES)) begin
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_AUG_PW;
        end
      end
      S_AUG_PW: begin
        prev_nxt  = par_rdata;
        mat_raddr = {par_rdata, cur_r};
        state_nxt = S_AUG_FW;
      end
      S_AUG_FW: begin
        mat_we    = 1'b1;
        mat_waddr = {prev_r, cur_r};
        mat_wdata = mat_rdata - f_r;
        mat_raddr = {cur_r, prev_r};
        state_nxt = S_AUG_BW;
      end
      S_AUG_BW: begin
        mat_we    = 1'b1;
        mat_waddr = {cur_r, prev_r};
        mat_wdata = bw_sum[RES_W] ? RES_MAX : bw_sum[RES_W-1:0];
        cur_nxt   = prev_r;
        hops_nxt  = hops_r + 1'b1;
        state_nxt = S_AUG_P;
      end
      S_FINISH: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_flow_nxt  = (flow_r > TOTAL_W'(OUT_MAX)) ? OUT_MAX : flow_r[FLOW_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
      node_count_r <= NCOUNT_W'(2);
      source_r     <= '0;
      sink_r       <= NODE_W'(1);
      visited_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      nx_r         <= '0;
      hops_r       <= '0;
      flow_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      visited_r   <= visited_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nx_r        <= nx_nxt;
      hops_r      <= hops_nxt;
      flow_r      <= flow_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_NODE_COUNT:  node_count_r <= cfg_wdata[NCOUNT_W-1:0];
          REG_SOURCE_NODE: source_r     <= cfg_wdata[NODE_W-1:0];
          REG_SINK_NODE:   sink_r       <= cfg_wdata[NODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    lim_r      <= lim_nxt;
    f_r        <= f_nxt;
    out_flow_r <= out_flow_nxt;
  end
endmodule
`default_nettype wire
